/* rtl/assert_macros.svh */
// Assertion helpers shared by the scheduler RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define PSCH_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define PSCH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds at the edge after the antecedent.
`define PSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/psch_pkg.sv */
`default_nettype none

package psch_pkg;

    localparam int MAX_TASKS_DEF     = 16;
    localparam int PRIORITY_BITS_DEF = 8;

    localparam int TIME_W      = 32;
    localparam int BURST_W     = 16;
    localparam int IN_PRIO_W   = 8;
    localparam int SLOT_PORT_W = 4;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // Broadcast from the controller to every slot cell.
    typedef struct packed {
        logic add_en;
        logic dec_en;
    } cell_ctl_t;

    // Flags of the candidate that travels along the cell chain.
    typedef struct packed {
        logic found;
        logic last;
    } cand_flags_t;

endpackage

`default_nettype wire

/* rtl/psch_cell.sv */
`default_nettype none

module psch_cell
    import psch_pkg::*;
#(
    parameter int MAX_TASKS     = MAX_TASKS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int CELL_INDEX    = 0,
    localparam int SLOT_W = $clog2(MAX_TASKS),
    localparam int CNT_W  = $clog2(MAX_TASKS + 1)
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  cell_ctl_t                ctl,
    input  wire  [CNT_W-1:0]         task_count,
    input  wire  [SLOT_W-1:0]        wr_idx,
    input  wire  [TIME_W-1:0]        wr_due,
    input  wire  [BURST_W-1:0]       wr_burst,
    input  wire  [PRIORITY_BITS-1:0] wr_prio,
    input  wire  [SLOT_W-1:0]        dec_idx,
    input  cand_flags_t              flags_in,
    input  wire  [PRIORITY_BITS-1:0] prio_in,
    input  wire  [SLOT_W-1:0]        idx_in,
    input  wire  [TIME_W-1:0]        due_in,
    output cand_flags_t              flags_out,
    output logic [PRIORITY_BITS-1:0] prio_out,
    output logic [SLOT_W-1:0]        idx_out,
    output logic [TIME_W-1:0]        due_out
);

    // Slot contents. The due value is arrival plus burst, so the waiting time
    // at completion is a single subtraction from the finish time.
    logic [TIME_W-1:0]        due_reg,  due_next;
    logic [BURST_W-1:0]       rem_reg,  rem_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;

    // Candidate stage handed to the next cell.
    cand_flags_t              cflags_reg, cflags_next;
    logic [PRIORITY_BITS-1:0] cprio_reg,  cprio_next;
    logic [SLOT_W-1:0]        cidx_reg,   cidx_next;
    logic [TIME_W-1:0]        cdue_reg,   cdue_next;

    logic used;
    logic take;

    assign used = CNT_W'(CELL_INDEX) < task_count;
    assign take = used && (rem_reg != '0) && (!flags_in.found || (prio_reg < prio_in));

    always_comb
    begin
        due_next  = due_reg;
        rem_next  = rem_reg;
        prio_next = prio_reg;
        if (ctl.add_en && (wr_idx == SLOT_W'(CELL_INDEX)))
        begin
            due_next  = wr_due;
            rem_next  = wr_burst;
            prio_next = wr_prio;
        end
        else if (ctl.dec_en && (dec_idx == SLOT_W'(CELL_INDEX)))
        begin
            rem_next = rem_reg - BURST_W'(1);
        end
    end

    always_comb
    begin
        if (take)
        begin
            cflags_next.found = 1'b1;
            cflags_next.last  = (rem_reg == BURST_W'(1));
            cprio_next        = prio_reg;
            cidx_next         = SLOT_W'(CELL_INDEX);
            cdue_next         = due_reg;
        end
        else
        begin
            cflags_next = flags_in;
            cprio_next  = prio_in;
            cidx_next   = idx_in;
            cdue_next   = due_in;
        end
    end

    always_ff @(posedge clk)
    begin
        due_reg   <= due_next;
        rem_reg   <= rem_next;
        prio_reg  <= prio_next;
        cprio_reg <= cprio_next;
        cidx_reg  <= cidx_next;
        cdue_reg  <= cdue_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cflags_reg <= '0;
        end
        else
        begin
            cflags_reg <= cflags_next;
        end
    end

    assign flags_out = cflags_reg;
    assign prio_out  = cprio_reg;
    assign idx_out   = cidx_reg;
    assign due_out   = cdue_reg;

endmodule

`default_nettype wire

/* rtl/preemptive_priority_scheduler_top.sv */
// Preemptive priority scheduler. A transaction is taken when start is high and busy is low;
// every transaction produces exactly one result, shown for a single cycle with done high,
// and the receiver cannot stall it, so it must capture the result in that cycle. An add's
// result appears in the cycle after the transaction and busy stays low. A tick's result
// is produced as follows: the best candidate is carried through the row of slot cells one
// cell per cycle, then the update state decrements the winner, advances the time and
// loads the result registers. Busy is high in the scan and update states and drops in the
// cycle the result is shown, so no new transaction is taken before that cycle.
`default_nettype none
`include "assert_macros.svh"

module preemptive_priority_scheduler_top
    import psch_pkg::*;
#(
    parameter int MAX_TASKS     = MAX_TASKS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    output logic                   busy,
    input  wire                    command,
    input  wire  [BURST_W-1:0]     burst_time,
    input  wire  [IN_PRIO_W-1:0]   task_priority,
    output logic                   done,
    output logic [SLOT_PORT_W-1:0] task_slot,
    output logic                   table_full,
    output logic                   idle,
    output logic                   finished,
    output logic [TIME_W-1:0]      waiting_time
);

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] step_reg,  step_next;
    logic [TIME_W-1:0] time_reg,  time_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic                   done_reg,  done_next;
    logic [SLOT_PORT_W-1:0] slot_reg,  slot_next;
    logic                   full_reg,  full_next;
    logic                   idle_reg,  idle_next;
    logic                   fin_reg,   fin_next;
    logic [TIME_W-1:0]      wait_reg,  wait_next;

    logic accept;
    logic add_go;
    logic tick_go;
    logic is_full;

    cell_ctl_t                ctl;
    logic [PRIORITY_BITS-1:0] wr_prio;
    logic [TIME_W-1:0]        wr_due;

    cand_flags_t              chain_flags [MAX_TASKS+1];
    logic [PRIORITY_BITS-1:0] chain_prio  [MAX_TASKS+1];
    logic [SLOT_W-1:0]        chain_idx   [MAX_TASKS+1];
    logic [TIME_W-1:0]        chain_due   [MAX_TASKS+1];

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign add_go  = accept && (command == CMD_ADD);
    assign tick_go = accept && (command == CMD_TICK);
    assign is_full = (count_reg == CNT_W'(MAX_TASKS));

    assign wr_prio = PRIORITY_BITS'(task_priority);
    assign wr_due  = time_reg + TIME_W'(burst_time);

    // The head of the chain starts with no candidate.
    assign chain_flags[0] = '0;
    assign chain_prio[0]  = '0;
    assign chain_idx[0]   = '0;
    assign chain_due[0]   = '0;

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        psch_cell #(
            .MAX_TASKS     (MAX_TASKS),
            .PRIORITY_BITS (PRIORITY_BITS),
            .CELL_INDEX    (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .task_count (count_reg),
            .wr_idx     (count_reg[SLOT_W-1:0]),
            .wr_due     (wr_due),
            .wr_burst   (burst_time),
            .wr_prio    (wr_prio),
            .dec_idx    (chain_idx[MAX_TASKS]),
            .flags_in   (chain_flags[i]),
            .prio_in    (chain_prio[i]),
            .idx_in     (chain_idx[i]),
            .due_in     (chain_due[i]),
            .flags_out  (chain_flags[i+1]),
            .prio_out   (chain_prio[i+1]),
            .idx_out    (chain_idx[i+1]),
            .due_out    (chain_due[i+1])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_go)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_reg == SLOT_W'(MAX_TASKS - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        ctl.add_en = add_go && !is_full;
        ctl.dec_en = 1'b0;
        step_next  = '0;
        time_next  = time_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        slot_next  = '0;
        full_next  = 1'b0;
        idle_next  = 1'b0;
        fin_next   = 1'b0;
        wait_next  = '0;

        if (add_go)
        begin
            done_next = 1'b1;
            full_next = is_full;
            if (!is_full)
            begin
                slot_next  = SLOT_PORT_W'(count_reg);
                count_next = count_reg + CNT_W'(1);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SCAN:
            begin
                step_next = step_reg + SLOT_W'(1);
            end
            ST_UPDATE:
            begin
                // The tail of the chain now holds the winner over all slots.
                done_next  = 1'b1;
                time_next  = time_reg + TIME_W'(1);
                ctl.dec_en = chain_flags[MAX_TASKS].found;
                idle_next  = !chain_flags[MAX_TASKS].found;
                if (chain_flags[MAX_TASKS].found)
                begin
                    slot_next = SLOT_PORT_W'(chain_idx[MAX_TASKS]);
                    if (chain_flags[MAX_TASKS].last)
                    begin
                        fin_next  = 1'b1;
                        wait_next = time_reg + TIME_W'(1) - chain_due[MAX_TASKS];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            time_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            time_reg  <= time_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        full_reg <= full_next;
        idle_reg <= idle_next;
        fin_reg  <= fin_next;
        wait_reg <= wait_next;
    end

    assign done         = done_reg;
    assign task_slot    = slot_reg;
    assign table_full   = full_reg;
    assign idle         = idle_reg;
    assign finished     = fin_reg;
    assign waiting_time = wait_reg;

    `PSCH_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(MAX_TASKS), "task count past table size")
    `PSCH_ASSERT_IMPL(a_result_flags, done, $countones({table_full, idle, finished}) <= 1, "conflicting result flags")
    `PSCH_ASSERT_NEXT(a_update_result, state_reg == ST_UPDATE, done && (time_reg == $past(time_reg) + TIME_W'(1)), "tick did not complete")
    `PSCH_ASSERT_NEXT(a_add_count, ctl.add_en, count_reg == $past(count_reg) + CNT_W'(1), "add did not take a slot")

endmodule

`default_nettype wire

/* sim/preemptive_priority_scheduler_top_tb.sv */
module preemptive_priority_scheduler_top_tb;
    import psch_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 750;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        logic                 cmd;
        logic [BURST_W-1:0]   burst;
        logic [IN_PRIO_W-1:0] prio;
        logic [3:0]           gap;
        logic                 drain;
    } sched_cmd_t;

    typedef struct packed {
        logic [SLOT_PORT_W-1:0] slot;
        logic                   full;
        logic                   idle;
        logic                   fin;
        logic [TIME_W-1:0]      wait_time;
    } sched_outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   command = CMD_TICK;
    logic [BURST_W-1:0]     burst_time = '0;
    logic [IN_PRIO_W-1:0]   task_priority = '0;
    wire                    busy;
    wire                    done;
    wire  [SLOT_PORT_W-1:0] task_slot;
    wire                    table_full;
    wire                    idle;
    wire                    finished;
    wire  [TIME_W-1:0]      waiting_time;

    sched_cmd_t     cmd_q[$];
    sched_outcome_t outcome_q[$];
    sched_cmd_t     cur_cmd = '0;
    bit             presenting = 1'b0;
    bit             gap_loaded = 1'b0;
    int             gap_left = 0;
    int             accepted_cnt = 0;
    int             mismatch_cnt = 0;
    bit             no_gaps = 1'b0;
    bit             drain_next = 1'b0;

    // Scheduler state as the predictor sees it.
    logic [TIME_W-1:0]    sched_now = '0;
    int                   tasks_used = 0;
    logic [TIME_W-1:0]    arrived_at[MAX_TASKS_DEF];
    logic [BURST_W-1:0]   burst_len[MAX_TASKS_DEF];
    logic [BURST_W-1:0]   ticks_left[MAX_TASKS_DEF];
    logic [IN_PRIO_W-1:0] prio_of[MAX_TASKS_DEF];

    preemptive_priority_scheduler_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .burst_time    (burst_time),
        .task_priority (task_priority),
        .done          (done),
        .task_slot     (task_slot),
        .table_full    (table_full),
        .idle          (idle),
        .finished      (finished),
        .waiting_time  (waiting_time)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    function automatic sched_outcome_t step_scheduler(input sched_cmd_t item);
        sched_outcome_t r;
        int             best;
        bit             found;
        r = '0;
        best = 0;
        found = 1'b0;
        if (item.cmd == CMD_ADD) begin
            if (tasks_used >= MAX_TASKS_DEF) begin
                r.full = 1'b1;
            end else begin
                r.slot = tasks_used[SLOT_PORT_W-1:0];
                arrived_at[tasks_used] = sched_now;
                burst_len[tasks_used] = item.burst;
                ticks_left[tasks_used] = item.burst;
                prio_of[tasks_used] = item.prio & IN_PRIO_W'((1 << PRIORITY_BITS_DEF) - 1);
                tasks_used++;
            end
        end else begin
            // Strict less-than keeps the lowest slot on equal priority.
            for (int i = 0; i < tasks_used; i++) begin
                if (ticks_left[i] != 0 && (!found || prio_of[i] < prio_of[best])) begin
                    best = i;
                    found = 1'b1;
                end
            end
            sched_now = sched_now + TIME_W'(1);
            if (!found) begin
                r.idle = 1'b1;
            end else begin
                r.slot = best[SLOT_PORT_W-1:0];
                ticks_left[best] = ticks_left[best] - BURST_W'(1);
                if (ticks_left[best] == 0) begin
                    r.fin = 1'b1;
                    r.wait_time = sched_now - arrived_at[best] - TIME_W'(burst_len[best]);
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    task automatic push_cmd(input logic c, input logic [BURST_W-1:0] b,
                            input logic [IN_PRIO_W-1:0] p);
        sched_cmd_t item;
        item.cmd = c;
        item.burst = b;
        item.prio = p;
        item.gap = no_gaps ? 4'd0 : 4'($urandom_range(0, 9));
        item.drain = drain_next;
        drain_next = 1'b0;
        cmd_q = {cmd_q, item};
    endtask

    // Driver: a transaction is taken at an edge where start is high and busy is low.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy) begin
                outcome_q = {outcome_q, step_scheduler(cur_cmd)};
                accepted_cnt++;
                presenting = 1'b0;
            end
            if (!presenting && cmd_q.size() > 0) begin
                if (!gap_loaded) begin
                    gap_left = int'(cmd_q[0].gap);
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(cmd_q[0].drain && outcome_q.size() != 0)) begin
                    cur_cmd = cmd_q.pop_front();
                    presenting = 1'b1;
                    gap_loaded = 1'b0;
                end
            end
            start <= presenting;
            command <= cur_cmd.cmd;
            burst_time <= cur_cmd.burst;
            task_priority <= cur_cmd.prio;
        end
    end

    // Monitor: results cannot be stalled, so every done cycle is checked.
    always @(posedge clk)
    begin
        sched_outcome_t exp_out;
        if (rst_n && done) begin
            if (outcome_q.size() == 0) begin
                $error("result with no transaction outstanding, task_slot 0x%0h", task_slot);
                mismatch_cnt++;
            end else begin
                exp_out = outcome_q.pop_front();
                check_field("task_slot", 32'(exp_out.slot), 32'(task_slot));
                check_field("table_full", 32'(exp_out.full), 32'(table_full));
                check_field("idle", 32'(exp_out.idle), 32'(idle));
                check_field("finished", 32'(exp_out.fin), 32'(finished));
                check_field("waiting_time", exp_out.wait_time, waiting_time);
            end
        end
    end

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("preemptive_priority_scheduler_top regression: fail");
        $finish;
    end

    initial
    begin
        int slots_given;
        int total;

        // Directed part: idle ticks, preemption, equal priorities, zero burst.
        push_cmd(CMD_TICK, 16'hFFFF, 8'hFF);
        push_cmd(CMD_ADD, 16'd1, 8'd0);
        push_cmd(CMD_TICK, 16'h0000, 8'h00);
        push_cmd(CMD_TICK, 16'h5A5A, 8'hA5);
        push_cmd(CMD_ADD, 16'd3, 8'd255);
        push_cmd(CMD_TICK, 16'd0, 8'd0);
        push_cmd(CMD_ADD, 16'd2, 8'd0);
        push_cmd(CMD_TICK, 16'd0, 8'd0);
        push_cmd(CMD_TICK, 16'd0, 8'd0);
        push_cmd(CMD_TICK, 16'd0, 8'd0);
        push_cmd(CMD_TICK, 16'd0, 8'd0);
        push_cmd(CMD_ADD, 16'd1, 8'd7);
        push_cmd(CMD_ADD, 16'd1, 8'd7);
        push_cmd(CMD_TICK, 16'd0, 8'd0);
        push_cmd(CMD_TICK, 16'd0, 8'd0);
        drain_next = 1'b1;
        push_cmd(CMD_ADD, 16'd0, 8'd0);
        push_cmd(CMD_TICK, 16'd0, 8'd0);
        slots_given = 6;

        // Random part. The last free slot gets the longest burst at the lowest
        // priority so that it only soaks up ticks nothing else wants.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            if (n % 150 == 75)
                drain_next = 1'b1;
            if ($urandom_range(0, 39) == 0) begin
                if (slots_given == MAX_TASKS_DEF - 1)
                    push_cmd(CMD_ADD, 16'hFFFF, 8'hFF);
                else
                    push_cmd(CMD_ADD, BURST_W'($urandom_range(1, 30)),
                             IN_PRIO_W'($urandom_range(0, 255)));
                if (slots_given < MAX_TASKS_DEF)
                    slots_given++;
            end else begin
                push_cmd(CMD_TICK, BURST_W'($urandom), IN_PRIO_W'($urandom));
            end
        end
        total = cmd_q.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < total || outcome_q.size() != 0)
            @(posedge clk);
        repeat (MAX_TASKS_DEF + 4) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("preemptive_priority_scheduler_top regression: pass");
        else
            $display("preemptive_priority_scheduler_top regression: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/psch_pkg.sv
rtl/psch_cell.sv
rtl/preemptive_priority_scheduler_top.sv
sim/preemptive_priority_scheduler_top_tb.sv
